FILE: hw/rtl/faq_pkg.sv
// Shared types, register codes and fp32 helper functions for the affine quantizer.
package faq_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALE = 2'd0;
    localparam logic [1:0] CFG_ZERO  = 2'd1;
    localparam logic [1:0] CFG_TYPE  = 2'd2;

    // Result type codes
    localparam logic [1:0] OT_INT8  = 2'd0;
    localparam logic [1:0] OT_UINT8 = 2'd1;
    localparam logic [1:0] OT_INT16 = 2'd2;
    localparam logic [1:0] OT_INT32 = 2'd3;

    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
    localparam logic [31:0] QNAN_BITS   = 32'h7FC0_0000;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic        is_last;
    } sample_item_t;

    typedef struct packed {
        logic signed [31:0] q_value;
        logic               last_out;
    } result_item_t;

    // Leading-zero count of a 49-bit word; an all-zero word gives 49.
    function automatic logic [5:0] lzc49(input logic [48:0] v);
        logic [5:0] c;
        logic       found;
        c     = 6'd49;
        found = 1'b0;
        for (int i = 48; i >= 0; i--) begin
            if (!found && v[i]) begin
                c     = 6'(48 - i);
                found = 1'b1;
            end
        end
        return c;
    endfunction

    // Round a normalised significand to fp32, nearest even.
    // Value is n / 2^47 * 2^(e - 127); n[47] is set unless n is zero.
    function automatic logic [31:0] fp_round(
        input logic              sgn,
        input logic signed [10:0] e,
        input logic [47:0]       n
    );
        logic [47:0] nn;
        logic [47:0] mask;
        logic [10:0] shw;
        logic [9:0]  em1;
        logic [23:0] m;
        logic        g;
        logic        s;
        logic        up;
        logic [32:0] pk;
        nn   = n;
        mask = '0;
        shw  = '0;
        em1  = '0;
        if (e > 11'sd0) begin
            em1 = e[9:0] - 10'd1;
        end
        else begin
            // subnormal result: denormalise, keep lost bits as sticky
            shw = 11'(11'sd1 - e);
            if (shw >= 11'd48) begin
                nn = {47'b0, |n};
            end
            else begin
                mask = ~({48{1'b1}} << shw[5:0]);
                nn   = (n >> shw[5:0]) | {47'b0, |(n & mask)};
            end
        end
        m  = nn[47:24];
        g  = nn[23];
        s  = |nn[22:0];
        up = g & (s | m[0]);
        // hidden bit carries into the exponent field
        pk = {em1, 23'b0} + 33'(m) + 33'(up);
        if (n == '0) begin
            return {sgn, 31'b0};
        end
        else if (pk >= (33'd255 << 23)) begin
            return {sgn, 8'hFF, 23'b0};
        end
        else begin
            return {sgn, pk[30:0]};
        end
    endfunction

endpackage

FILE: hw/rtl/fp32_affine_quantizer_top.sv
// Top level of the fp32 affine quantizer: eight-stage float pipeline with item handshake.
//
// Takes one IEEE fp32 sample per item and returns round_half_away(sample * scale + zp),
// where the product and the sum are each rounded to fp32 nearest even, zp is the zero
// point converted to fp32, and the integer is clamped to the type chosen by out_type
// (int8, uint8, int16, int32). NaN gives 0; infinities and values beyond int32
// saturate. Subnormals are handled in full, no flush to zero. One item enters per
// clock while sample_stall is low: the block is eight register stages (multiply,
// normalise, round, align and add, normalise, round, integer round, clamp), and a
// result is offered from the clamp stage's output register. Each stage
// carries its own valid bit and moves whenever the stage after it is empty or moving,
// so bubbles close up and result_stall only stops the input once every stage holds an
// item. Write configuration only while no item is in flight; a written zero point takes
// effect only after it passes through the registers of the zero-point conversion.
module fp32_affine_quantizer_top
    import faq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_item_t sample,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // ---------------- configuration ----------------
    logic [31:0] scale_reg;
    logic [31:0] zero_reg;
    logic [1:0]  type_reg;
    logic [31:0] zp_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            zero_reg  <= '0;
            type_reg  <= OT_INT8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCALE: scale_reg <= cfg_data;
                CFG_ZERO:  zero_reg  <= cfg_data;
                CFG_TYPE:  type_reg  <= cfg_data[1:0];
                default:   ;  // drop writes beyond the register list
            endcase
        end
    end

    faq_zp_conv u_zp_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .zero_offset ($signed(zero_reg)),
        .zp_bits     (zp_bits)
    );

    // ---------------- pipeline flow control ----------------
    logic [8:1] valid_reg;
    logic [8:1] move;

    always_comb
    begin
        move[8] = !valid_reg[8] || !result_stall;
        for (int i = 7; i >= 1; i--)
        begin
            move[i] = !valid_reg[i] || move[i+1];
        end
    end

    assign sample_stall = !move[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (move[1])
            begin
                valid_reg[1] <= sample_valid;
            end
            for (int i = 2; i <= 8; i++)
            begin
                if (move[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ---------------- stage 1: unpack and multiply significands ----------------
    logic        s1_sgn_reg, s1_sgn_next;
    logic [8:0]  s1_esum_reg, s1_esum_next;
    logic [47:0] s1_prod_reg, s1_prod_next;
    logic        s1_nan_reg, s1_nan_next;
    logic        s1_inf_reg, s1_inf_next;
    logic        s1_last_reg;
    logic [7:0]  x_exp, s_exp;
    logic        x_nan, x_inf, x_zero, s_nan, s_inf, s_zero;

    always_comb
    begin
        x_exp  = sample.sample_bits[30:23];
        s_exp  = scale_reg[30:23];
        x_nan  = (x_exp == 8'hFF) && (sample.sample_bits[22:0] != '0);
        x_inf  = (x_exp == 8'hFF) && (sample.sample_bits[22:0] == '0);
        x_zero = (x_exp == 8'h00) && (sample.sample_bits[22:0] == '0);
        s_nan  = (s_exp == 8'hFF) && (scale_reg[22:0] != '0);
        s_inf  = (s_exp == 8'hFF) && (scale_reg[22:0] == '0);
        s_zero = (s_exp == 8'h00) && (scale_reg[22:0] == '0);
        s1_sgn_next  = sample.sample_bits[31] ^ scale_reg[31];
        s1_esum_next = 9'((x_exp == 8'h00) ? 8'd1 : x_exp)
                     + 9'((s_exp == 8'h00) ? 8'd1 : s_exp);
        s1_prod_next = {24'b0, (x_exp != 8'h00), sample.sample_bits[22:0]}
                     * {24'b0, (s_exp != 8'h00), scale_reg[22:0]};
        s1_nan_next  = x_nan || s_nan || (x_inf && s_zero) || (x_zero && s_inf);
        s1_inf_next  = (x_inf || s_inf) && !s1_nan_next;
    end

    always_ff @(posedge clk)
    begin
        if (move[1])
        begin
            s1_sgn_reg  <= s1_sgn_next;
            s1_esum_reg <= s1_esum_next;
            s1_prod_reg <= s1_prod_next;
            s1_nan_reg  <= s1_nan_next;
            s1_inf_reg  <= s1_inf_next;
            s1_last_reg <= sample.is_last;
        end
    end

    // ---------------- stage 2: normalise product ----------------
    logic               s2_sgn_reg, s2_nan_reg, s2_inf_reg, s2_last_reg;
    logic signed [10:0] s2_e_reg, s2_e_next;
    logic [47:0]        s2_n_reg, s2_n_next;
    logic [5:0]         s2_lz;
    logic [48:0]        s2_sh;

    always_comb
    begin
        s2_lz     = lzc49({s1_prod_reg, 1'b0});
        s2_sh     = {s1_prod_reg, 1'b0} << s2_lz;
        s2_n_next = s2_sh[48:1];
        s2_e_next = $signed(11'(s1_esum_reg) - 11'd126 - 11'(s2_lz));
    end

    always_ff @(posedge clk)
    begin
        if (move[2])
        begin
            s2_sgn_reg  <= s1_sgn_reg;
            s2_nan_reg  <= s1_nan_reg;
            s2_inf_reg  <= s1_inf_reg;
            s2_last_reg <= s1_last_reg;
            s2_e_reg    <= s2_e_next;
            s2_n_reg    <= s2_n_next;
        end
    end

    // ---------------- stage 3: round product to fp32 ----------------
    logic [31:0] s3_p_reg, s3_p_next;
    logic        s3_last_reg;

    always_comb
    begin
        if (s2_nan_reg)
            s3_p_next = QNAN_BITS;
        else if (s2_inf_reg)
            s3_p_next = {s2_sgn_reg, 8'hFF, 23'b0};
        else
            s3_p_next = fp_round(s2_sgn_reg, s2_e_reg, s2_n_reg);
    end

    always_ff @(posedge clk)
    begin
        if (move[3])
        begin
            s3_p_reg    <= s3_p_next;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ---------------- stage 4: align and add the zero point ----------------
    logic        s4_sgn_reg, s4_sgn_next;
    logic [7:0]  s4_e_reg, s4_e_next;
    logic [48:0] s4_sum_reg, s4_sum_next;
    logic        s4_nan_reg, s4_nan_next;
    logic        s4_inf_reg, s4_inf_next;
    logic        s4_last_reg;
    logic [31:0] opa, opb;
    logic [7:0]  ea, eb, dexp;
    logic [47:0] sbf, sbs, sbmask;
    logic [48:0] sa;

    always_comb
    begin
        // larger magnitude goes to the A side
        if (s3_p_reg[30:0] >= zp_bits[30:0])
        begin
            opa = s3_p_reg;
            opb = zp_bits;
        end
        else
        begin
            opa = zp_bits;
            opb = s3_p_reg;
        end
        ea     = (opa[30:23] == 8'h00) ? 8'd1 : opa[30:23];
        eb     = (opb[30:23] == 8'h00) ? 8'd1 : opb[30:23];
        dexp   = ea - eb;
        sa     = {1'b0, (opa[30:23] != 8'h00), opa[22:0], 24'b0};
        sbf    = {(opb[30:23] != 8'h00), opb[22:0], 24'b0};
        sbmask = '0;
        if (dexp >= 8'd48)
        begin
            sbs = {47'b0, |sbf};
        end
        else
        begin
            sbmask = ~({48{1'b1}} << dexp[5:0]);
            sbs    = (sbf >> dexp[5:0]) | {47'b0, |(sbf & sbmask)};
        end
        s4_sum_next = (opa[31] ^ opb[31]) ? (sa - {1'b0, sbs}) : (sa + {1'b0, sbs});
        s4_sgn_next = opa[31];
        s4_e_next   = ea;
        // the zero point is always finite, so specials come from the product
        s4_nan_next = (s3_p_reg[30:23] == 8'hFF) && (s3_p_reg[22:0] != '0);
        s4_inf_next = (s3_p_reg[30:23] == 8'hFF) && (s3_p_reg[22:0] == '0);
        if (s4_inf_next)
            s4_sgn_next = s3_p_reg[31];
    end

    always_ff @(posedge clk)
    begin
        if (move[4])
        begin
            s4_sgn_reg  <= s4_sgn_next;
            s4_e_reg    <= s4_e_next;
            s4_sum_reg  <= s4_sum_next;
            s4_nan_reg  <= s4_nan_next;
            s4_inf_reg  <= s4_inf_next;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ---------------- stage 5: normalise sum ----------------
    logic               s5_sgn_reg, s5_nan_reg, s5_inf_reg, s5_last_reg;
    logic signed [10:0] s5_e_reg, s5_e_next;
    logic [47:0]        s5_n_reg, s5_n_next;
    logic [5:0]         s5_lz;
    logic [48:0]        s5_sh;

    always_comb
    begin
        s5_lz     = lzc49(s4_sum_reg);
        s5_sh     = s4_sum_reg << s5_lz;
        s5_n_next = {s5_sh[48:2], s5_sh[1] | s5_sh[0]};
        s5_e_next = $signed(11'(s4_e_reg) + 11'd1 - 11'(s5_lz));
    end

    always_ff @(posedge clk)
    begin
        if (move[5])
        begin
            s5_sgn_reg  <= s4_sgn_reg;
            s5_nan_reg  <= s4_nan_reg;
            s5_inf_reg  <= s4_inf_reg;
            s5_last_reg <= s4_last_reg;
            s5_e_reg    <= s5_e_next;
            s5_n_reg    <= s5_n_next;
        end
    end

    // ---------------- stage 6: round sum to fp32 ----------------
    logic [31:0] s6_t_reg, s6_t_next;
    logic        s6_last_reg;

    always_comb
    begin
        if (s5_nan_reg)
            s6_t_next = QNAN_BITS;
        else if (s5_inf_reg)
            s6_t_next = {s5_sgn_reg, 8'hFF, 23'b0};
        else
            s6_t_next = fp_round(s5_sgn_reg, s5_e_reg, s5_n_reg);
    end

    always_ff @(posedge clk)
    begin
        if (move[6])
        begin
            s6_t_reg    <= s6_t_next;
            s6_last_reg <= s5_last_reg;
        end
    end

    // ---------------- stage 7: round to integer, half away from zero ----------------
    logic        s7_sgn_reg, s7_sat_reg, s7_nan_reg, s7_last_reg;
    logic [30:0] s7_mag_reg, s7_mag_next;
    logic        s7_sat_next, s7_nan_next;
    logic [7:0]  t_exp;
    logic [23:0] t_m;
    logic [7:0]  rsh;
    logic [25:0] rsum;
    logic [25:0] rhalf;

    always_comb
    begin
        t_exp       = s6_t_reg[30:23];
        t_m         = {(t_exp != 8'h00), s6_t_reg[22:0]};
        s7_nan_next = (t_exp == 8'hFF) && (s6_t_reg[22:0] != '0);
        s7_sat_next = (t_exp >= 8'd158);
        rsh         = 8'd150 - t_exp;
        rhalf       = '0;
        rsum        = '0;
        if (t_exp >= 8'd150)
        begin
            s7_mag_next = 31'(t_m) << (t_exp - 8'd150);
        end
        else if (rsh > 8'd25)
        begin
            s7_mag_next = '0;
        end
        else
        begin
            rhalf       = 26'd1 << (rsh[4:0] - 5'd1);
            rsum        = (26'(t_m) + rhalf) >> rsh[4:0];
            s7_mag_next = 31'(rsum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (move[7])
        begin
            s7_sgn_reg  <= s6_t_reg[31];
            s7_sat_reg  <= s7_sat_next;
            s7_nan_reg  <= s7_nan_next;
            s7_mag_reg  <= s7_mag_next;
            s7_last_reg <= s6_last_reg;
        end
    end

    // ---------------- stage 8: sign, saturate and clamp; output register ----------------
    logic signed [31:0] s8_q_reg, s8_q_next;
    logic               s8_last_reg;
    logic signed [31:0] q32, lo, hi;

    always_comb
    begin
        if (s7_nan_reg)
            q32 = '0;
        else if (s7_sat_reg)
            q32 = s7_sgn_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (s7_sgn_reg)
            q32 = -$signed({1'b0, s7_mag_reg});
        else
            q32 = $signed({1'b0, s7_mag_reg});
        case (type_reg)
            OT_INT8:  begin lo = -32'sd128;    hi = 32'sd127;    end
            OT_UINT8: begin lo = 32'sd0;       hi = 32'sd255;    end
            OT_INT16: begin lo = -32'sd32768;  hi = 32'sd32767;  end
            default:  begin lo = 32'sh8000_0000; hi = 32'sh7FFF_FFFF; end
        endcase
        if (q32 < lo)
            s8_q_next = lo;
        else if (q32 > hi)
            s8_q_next = hi;
        else
            s8_q_next = q32;
    end

    always_ff @(posedge clk)
    begin
        if (move[8])
        begin
            s8_q_reg    <= s8_q_next;
            s8_last_reg <= s7_last_reg;
        end
    end

    assign result_valid    = valid_reg[8];
    assign result.q_value  = s8_q_reg;
    assign result.last_out = s8_last_reg;

`ifndef ASSERT_OFF
    // input is held back only when every stage is occupied
    a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (valid_reg == '1))
        else $error("input stalled with a bubble in the pipeline");

    // a taken result is replaced at once when stage 7 holds an item
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && valid_reg[7]) |=> result_valid)
        else $error("result slot not refilled");

    // a NaN item reaches the output as zero
    a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[7] && s7_nan_reg && move[8]) |=> (result.q_value == 32'sd0))
        else $error("NaN did not give zero");
`endif

endmodule

FILE: hw/rtl/faq_zp_conv.sv
// Two-stage conversion of the signed integer zero point to fp32, nearest even.
module faq_zp_conv
    import faq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] zero_offset,
    output logic [31:0]        zp_bits
);

    logic               sgn_reg, sgn_next;
    logic signed [10:0] e_reg, e_next;
    logic [47:0]        n_reg, n_next;
    logic [31:0]        zp_reg, zp_next;
    logic [31:0]        mag;
    logic [5:0]         lz;
    logic [48:0]        sh;

    always_comb
    begin
        sgn_next = zero_offset[31];
        mag      = zero_offset[31] ? 32'(-zero_offset) : 32'(zero_offset);
        lz       = lzc49({mag, 17'b0});
        sh       = {mag, 17'b0} << lz;
        n_next   = sh[48:1];
        e_next   = $signed(11'd158 - 11'(lz));
        zp_next  = fp_round(sgn_reg, e_reg, n_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sgn_reg <= 1'b0;
            e_reg   <= '0;
            n_reg   <= '0;
            zp_reg  <= '0;
        end
        else
        begin
            sgn_reg <= sgn_next;
            e_reg   <= e_next;
            n_reg   <= n_next;
            zp_reg  <= zp_next;
        end
    end

    assign zp_bits = zp_reg;

endmodule
